[sv/fpes_pkg.sv]
// ----------------------------------------------------------------------------
// fpes_pkg
// shared types, codes and constants of the flash program/erase sequencer
// ----------------------------------------------------------------------------
package fpes_pkg;

  // command opcodes
  localparam logic [1:0] OP_PROGRAM  = 2'd0;
  localparam logic [1:0] OP_ERASE    = 2'd1;
  localparam logic [1:0] OP_IDENTIFY = 2'd2;
  localparam logic [1:0] OP_READ_RSP = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_ADDR_SHIFT   = 2'd0;
  localparam logic [1:0] CFG_DEVICE_START = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT   = 2'd2;

  localparam logic [22:0] POLL_LIMIT_RESET = 23'd5000000;

  // completion status
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERROR   = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // front phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_POLL  = 3'd1;
  localparam logic [2:0] PH_PRE0  = 3'd2;
  localparam logic [2:0] PH_PRE1  = 3'd3;
  localparam logic [2:0] PH_POST0 = 3'd4;
  localparam logic [2:0] PH_POST1 = 3'd5;

  // jobs handed from front to back
  localparam logic [2:0] JOB_PROGRAM  = 3'd0;
  localparam logic [2:0] JOB_ERASE    = 3'd1;
  localparam logic [2:0] JOB_ID_READ0 = 3'd2;
  localparam logic [2:0] JOB_ID_READ1 = 3'd3;
  localparam logic [2:0] JOB_POLL     = 3'd4;
  localparam logic [2:0] JOB_DONE     = 3'd5;
  localparam logic [2:0] JOB_ENTER    = 3'd6;
  localparam logic [2:0] JOB_EXIT     = 3'd7;

  // bus patterns
  localparam logic [31:0] UNLOCK_A    = 32'h0000_5555;
  localparam logic [31:0] UNLOCK_B    = 32'h0000_2aaa;
  localparam logic [31:0] UNLOCK_MASK = 32'h0001_ffff;
  localparam logic [7:0]  D_UNLOCK1   = 8'haa;
  localparam logic [7:0]  D_UNLOCK2   = 8'h55;
  localparam logic [7:0]  D_PROGRAM   = 8'ha0;
  localparam logic [7:0]  D_ERASE     = 8'h80;
  localparam logic [7:0]  D_SECTOR    = 8'h30;
  localparam logic [7:0]  D_AUTOSEL   = 8'h90;
  localparam logic [7:0]  D_RESET     = 8'hf0;
  localparam logic [7:0]  ERASED_BYTE = 8'hff;
  localparam int          ERR_BIT     = 5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic        bus_write;
    logic [31:0] bus_address;
    logic [7:0]  bus_data;
    logic        command_done;
    logic [1:0]  status;
    logic [15:0] family_code;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] address;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [15:0] family;
  } job_t;

  typedef struct packed {
    logic [1:0]  addr_shift;
    logic [31:0] device_start;
  } bus_cfg_t;

endpackage

[sv/fpes_if.sv]
// ----------------------------------------------------------------------------
// fpes channel interfaces
// valid/ready channels for commands and bus results
// ----------------------------------------------------------------------------
interface fpes_cmd_if import fpes_pkg::*;;
  logic valid;
  logic ready;
  cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface fpes_res_if import fpes_pkg::*;;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[sv/fpes_front.sv]
// ----------------------------------------------------------------------------
// fpes_front
// accepts commands and read responses, tracks the sequence, queues jobs
// ----------------------------------------------------------------------------
module fpes_front import fpes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  fpes_cmd_if.sink    cmd,
  input  logic [22:0] poll_limit,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_job
);

  logic [2:0]  phase, phase_next;
  logic [31:0] target_address, target_address_next;
  logic [7:0]  expected_byte, expected_byte_next;
  logic [22:0] poll_count, poll_count_next;
  logic [7:0]  first_id_byte, first_id_byte_next;
  logic [15:0] prior_code, prior_code_next;
  logic        accept;
  logic        has_job;
  logic [22:0] count_inc;
  logic [15:0] code;

  assign cmd.ready = !q_full;
  assign accept    = cmd.valid && cmd.ready;
  assign q_push    = accept && has_job;
  assign count_inc = poll_count + 23'd1;
  assign code      = {first_id_byte, cmd.payload.data};

  always_comb begin
    phase_next          = phase;
    target_address_next = target_address;
    expected_byte_next  = expected_byte;
    poll_count_next     = poll_count;
    first_id_byte_next  = first_id_byte;
    prior_code_next     = prior_code;
    has_job             = 1'b0;
    q_job               = '0;
    q_job.address       = cmd.payload.address;
    q_job.data          = cmd.payload.data;
    if (cmd.payload.opcode != OP_READ_RSP) begin
      if (phase == PH_IDLE) begin
        has_job = 1'b1;
        case (cmd.payload.opcode)
          OP_PROGRAM, OP_ERASE: begin
            q_job.kind = (cmd.payload.opcode == OP_PROGRAM) ? JOB_PROGRAM : JOB_ERASE;
            expected_byte_next  = (cmd.payload.opcode == OP_PROGRAM) ?
                                  cmd.payload.data : ERASED_BYTE;
            target_address_next = cmd.payload.address;
            poll_count_next     = '0;
            phase_next          = PH_POLL;
          end
          default: begin
            q_job.kind = JOB_ID_READ0;
            phase_next = PH_PRE0;
          end
        endcase
      end
    end else begin
      case (phase)
        PH_POLL: begin
          has_job         = 1'b1;
          poll_count_next = count_inc;
          q_job.kind      = JOB_DONE;
          if (cmd.payload.data == expected_byte) begin
            q_job.status = ST_OK;
            phase_next   = PH_IDLE;
          end else if (cmd.payload.data[ERR_BIT]) begin
            q_job.status = ST_ERROR;
            phase_next   = PH_IDLE;
          end else if (count_inc >= poll_limit) begin
            q_job.status = ST_TIMEOUT;
            phase_next   = PH_IDLE;
          end else begin
            q_job.kind    = JOB_POLL;
            q_job.address = target_address;
          end
        end
        PH_PRE0, PH_POST0: begin
          has_job            = 1'b1;
          first_id_byte_next = cmd.payload.data;
          q_job.kind         = JOB_ID_READ1;
          phase_next         = (phase == PH_PRE0) ? PH_PRE1 : PH_POST1;
        end
        PH_PRE1: begin
          has_job         = 1'b1;
          prior_code_next = code;
          q_job.kind      = JOB_ENTER;
          phase_next      = PH_POST0;
        end
        PH_POST1: begin
          has_job      = 1'b1;
          q_job.kind   = JOB_EXIT;
          q_job.family = (code == prior_code) ? 16'd0 : code;
          phase_next   = PH_IDLE;
        end
        default: begin
          has_job = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      target_address <= '0;
      expected_byte  <= '0;
      poll_count     <= '0;
      first_id_byte  <= '0;
      prior_code     <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      target_address <= target_address_next;
      expected_byte  <= expected_byte_next;
      poll_count     <= poll_count_next;
      first_id_byte  <= first_id_byte_next;
      prior_code     <= prior_code_next;
    end
  end

endmodule

[sv/fpes_queue.sv]
// ----------------------------------------------------------------------------
// fpes_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module fpes_queue import fpes_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = (fill == QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[sv/fpes_back.sv]
// ----------------------------------------------------------------------------
// fpes_back
// expands queued jobs into bus accesses and completion notices
// ----------------------------------------------------------------------------
module fpes_back import fpes_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  bus_cfg_t bus_cfg,
  input  job_t     head,
  input  logic     q_empty,
  output logic     q_pop,
  fpes_res_if.source res
);

  logic [2:0]  step;
  logic [2:0]  last_step;
  logic        load;
  res_t        item;
  logic [31:0] clr_mask, ua, ub, ia, ib, i0, i1;

  // unlock addresses inside the target's block and at the device base, and the identify read addresses
  always_comb begin
    clr_mask = ~(UNLOCK_MASK << bus_cfg.addr_shift);
    ua = (head.address & clr_mask) | (UNLOCK_A << bus_cfg.addr_shift);
    ub = (head.address & clr_mask) | (UNLOCK_B << bus_cfg.addr_shift);
    ia = bus_cfg.device_start | (UNLOCK_A << bus_cfg.addr_shift);
    ib = bus_cfg.device_start | (UNLOCK_B << bus_cfg.addr_shift);
    i0 = bus_cfg.device_start;
    i1 = bus_cfg.device_start | (32'd1 << bus_cfg.addr_shift);
  end

  always_comb begin
    item      = '0;
    last_step = 3'd0;
    case (head.kind)
      JOB_PROGRAM: begin
        last_step = 3'd4;
        item.bus_write = 1'b1;
        case (step)
          3'd0:    begin item.bus_address = ua; item.bus_data = D_UNLOCK1; end
          3'd1:    begin item.bus_address = ub; item.bus_data = D_UNLOCK2; end
          3'd2:    begin item.bus_address = ua; item.bus_data = D_PROGRAM; end
          3'd3:    begin item.bus_address = head.address; item.bus_data = head.data; end
          default: begin item.bus_write = 1'b0; item.bus_address = head.address; end
        endcase
      end
      JOB_ERASE: begin
        last_step = 3'd6;
        item.bus_write = 1'b1;
        case (step)
          3'd0:    begin item.bus_address = ua; item.bus_data = D_UNLOCK1; end
          3'd1:    begin item.bus_address = ub; item.bus_data = D_UNLOCK2; end
          3'd2:    begin item.bus_address = ua; item.bus_data = D_ERASE; end
          3'd3:    begin item.bus_address = ua; item.bus_data = D_UNLOCK1; end
          3'd4:    begin item.bus_address = ub; item.bus_data = D_UNLOCK2; end
          3'd5:    begin item.bus_address = head.address; item.bus_data = D_SECTOR; end
          default: begin item.bus_write = 1'b0; item.bus_address = head.address; end
        endcase
      end
      JOB_ID_READ0: item.bus_address = i0;
      JOB_ID_READ1: item.bus_address = i1;
      JOB_POLL:     item.bus_address = head.address;
      JOB_DONE: begin
        item.command_done = 1'b1;
        item.status       = head.status;
      end
      JOB_ENTER, JOB_EXIT: begin
        last_step = 3'd3;
        item.bus_write = 1'b1;
        case (step)
          3'd0: begin item.bus_address = ia; item.bus_data = D_UNLOCK1; end
          3'd1: begin item.bus_address = ib; item.bus_data = D_UNLOCK2; end
          3'd2: begin
            item.bus_address = ia;
            item.bus_data    = (head.kind == JOB_ENTER) ? D_AUTOSEL : D_RESET;
          end
          default: begin
            item.bus_write = 1'b0;
            if (head.kind == JOB_ENTER) begin
              item.bus_address = i0;
            end else begin
              item.command_done = 1'b1;
              item.family_code  = head.family;
            end
          end
        endcase
      end
      default: item = '0;
    endcase
    item.last_of_run = (step == last_step);
  end

  assign load  = !q_empty && (!res.valid || res.ready);
  assign q_pop = load && (step == last_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      res.valid <= 1'b1;
      step      <= (step == last_step) ? 3'd0 : step + 3'd1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res.payload <= item;
  end

endmodule

[sv/flash_program_erase_sequencer.sv]
// ----------------------------------------------------------------------------
// flash_program_erase_sequencer
// host-side command sequencer for 29F-style parallel flash
// ----------------------------------------------------------------------------
// an accepted input's job is written into the queue, and the back end
//   registers each result; an input fans out into 0 to 7 results
// throughput: one input per cycle while the 4-entry job queue has room, one
//   result per cycle unless res stalls; the results set the sustained rate
// reset: synchronous active-high rst empties the queue and output register,
//   returns to idle and loads addr_shift 0, device_start 0, poll_limit 5000000
module flash_program_erase_sequencer import fpes_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  fpes_cmd_if.sink    cmd,
  fpes_res_if.source  res
);

  // configuration registers
  logic [1:0]  addr_shift;
  logic [31:0] device_start;
  logic [22:0] poll_limit;
  bus_cfg_t    bus_cfg;

  // job queue hookup
  logic q_push, q_full, q_pop, q_empty;
  job_t q_job, q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_shift   <= '0;
      device_start <= '0;
      poll_limit   <= POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADDR_SHIFT:   addr_shift   <= cfg_data[1:0];
        CFG_DEVICE_START: device_start <= cfg_data;
        CFG_POLL_LIMIT:   poll_limit   <= cfg_data[22:0];
        default:          ;
      endcase
    end
  end

  assign bus_cfg.addr_shift   = addr_shift;
  assign bus_cfg.device_start = device_start;

  // front: decodes commands and read responses into jobs, owns sequence state
  fpes_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .poll_limit (poll_limit),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_job      (q_job)
  );

  // queue: lets the front keep taking transactions while the back is stalled
  fpes_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // back: walks each job's bus transactions into the output register
  fpes_back u_back (
    .clk     (clk),
    .rst     (rst),
    .bus_cfg (bus_cfg),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .res     (res)
  );

endmodule

[sv/fpes_checker.sv]
// ----------------------------------------------------------------------------
// fpes_checker
// port-level checks on the result channel of the sequencer
// ----------------------------------------------------------------------------
module fpes_checker import fpes_pkg::*; (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res_payload
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_payload))
    else $error("result changed while stalled");

  // nothing shown right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // a completion notice ends its run and carries no bus access
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_payload.command_done |->
      res_payload.last_of_run && !res_payload.bus_write &&
      res_payload.bus_address == 32'd0 && res_payload.bus_data == 8'd0)
    else $error("bad completion notice");

  // status and family code only on completion
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_payload.command_done |->
      res_payload.status == ST_OK && res_payload.family_code == 16'd0)
    else $error("status outside completion");

  // a read request never carries data
  a_read_nodata: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_payload.bus_write |-> res_payload.bus_data == 8'd0)
    else $error("read request with data");

endmodule

bind flash_program_erase_sequencer fpes_checker u_fpes_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_payload (res.payload)
);

[verif/flash_program_erase_sequencer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_program_erase_sequencer_tb
// self-checking bench for the flash command sequencer: directed and random
// command streams with read responses, an in-bench model of the sequencer
// predicting every bus access and completion notice, random idling on both
// channels, and configuration changes between quiet phases
// ----------------------------------------------------------------------------
module flash_program_erase_sequencer_tb;
  import fpes_pkg::*;

  // --------------------------------------------------------------------------
  // scoreboard: tracks the sequencer state, predicts the bus accesses caused
  // by each accepted transaction and checks them in order
  // --------------------------------------------------------------------------
  class flash_bus_scoreboard;
    res_t        bus_ops_due[$];
    res_t        burst[$];
    int          failures;
    // register copies
    logic [1:0]  shift;
    logic [31:0] dev_base;
    logic [22:0] limit;
    // sequencer state
    logic [2:0]  phase;
    logic [31:0] target;
    logic [7:0]  expected_byte;
    logic [22:0] polls;
    logic [7:0]  id_hi;
    logic [15:0] prior_code;

    function new();
      failures      = 0;
      shift         = '0;
      dev_base      = '0;
      limit         = POLL_LIMIT_RESET;
      phase         = PH_IDLE;
      target        = '0;
      expected_byte = '0;
      polls         = '0;
      id_hi         = '0;
      prior_code    = '0;
    endfunction

    function void write_reg(logic [1:0] index, logic [31:0] value);
      case (index)
        CFG_ADDR_SHIFT:   shift = value[1:0];
        CFG_DEVICE_START: dev_base = value;
        CFG_POLL_LIMIT:   limit = value[22:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return bus_ops_due.size();
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    // read data that moves the current command towards its end
    function logic [7:0] closing_byte();
      if (phase == PH_POLL) return expected_byte;
      return 8'($urandom);
    endfunction

    // unlock address inside the sector of the target
    function logic [31:0] unlock_at(logic [31:0] t, logic [31:0] pat);
      return (t & ~(UNLOCK_MASK << shift)) | (pat << shift);
    endfunction

    function logic [31:0] id_at(logic [31:0] pat);
      return dev_base | (pat << shift);
    endfunction

    function void emit(logic wr, logic [31:0] adr, logic [7:0] dat, logic done,
                       logic [1:0] st, logic [15:0] fam);
      res_t r;
      r.bus_write    = wr;
      r.bus_address  = adr;
      r.bus_data     = dat;
      r.command_done = done;
      r.status       = st;
      r.family_code  = fam;
      r.last_of_run  = 1'b0;
      burst.push_back(r);
    endfunction

    function void note_input(cmd_t c);
      logic [31:0] a;
      logic [31:0] b;
      logic [15:0] code;
      res_t        r;
      if (c.opcode != OP_READ_RSP) begin
        // commands while busy are dropped
        if (phase == PH_IDLE) begin
          if (c.opcode == OP_IDENTIFY) begin
            emit(1'b0, id_at(32'd0), 8'd0, 1'b0, ST_OK, 16'd0);
            phase = PH_PRE0;
          end else begin
            a = unlock_at(c.address, UNLOCK_A);
            b = unlock_at(c.address, UNLOCK_B);
            emit(1'b1, a, D_UNLOCK1, 1'b0, ST_OK, 16'd0);
            emit(1'b1, b, D_UNLOCK2, 1'b0, ST_OK, 16'd0);
            if (c.opcode == OP_PROGRAM) begin
              emit(1'b1, a, D_PROGRAM, 1'b0, ST_OK, 16'd0);
              emit(1'b1, c.address, c.data, 1'b0, ST_OK, 16'd0);
              expected_byte = c.data;
            end else begin
              emit(1'b1, a, D_ERASE, 1'b0, ST_OK, 16'd0);
              emit(1'b1, a, D_UNLOCK1, 1'b0, ST_OK, 16'd0);
              emit(1'b1, b, D_UNLOCK2, 1'b0, ST_OK, 16'd0);
              emit(1'b1, c.address, D_SECTOR, 1'b0, ST_OK, 16'd0);
              expected_byte = ERASED_BYTE;
            end
            emit(1'b0, c.address, 8'd0, 1'b0, ST_OK, 16'd0);
            target = c.address;
            polls  = '0;
            phase  = PH_POLL;
          end
        end
      end else begin
        case (phase)
          PH_POLL: begin
            polls = polls + 23'd1;
            if (c.data == expected_byte) begin
              emit(1'b0, 32'd0, 8'd0, 1'b1, ST_OK, 16'd0);
              phase = PH_IDLE;
            end else if (c.data[ERR_BIT]) begin
              emit(1'b0, 32'd0, 8'd0, 1'b1, ST_ERROR, 16'd0);
              phase = PH_IDLE;
            end else if (polls >= limit) begin
              emit(1'b0, 32'd0, 8'd0, 1'b1, ST_TIMEOUT, 16'd0);
              phase = PH_IDLE;
            end else begin
              emit(1'b0, target, 8'd0, 1'b0, ST_OK, 16'd0);
            end
          end
          PH_PRE0: begin
            id_hi = c.data;
            emit(1'b0, id_at(32'd1), 8'd0, 1'b0, ST_OK, 16'd0);
            phase = PH_PRE1;
          end
          PH_PRE1: begin
            prior_code = {id_hi, c.data};
            emit(1'b1, id_at(UNLOCK_A), D_UNLOCK1, 1'b0, ST_OK, 16'd0);
            emit(1'b1, id_at(UNLOCK_B), D_UNLOCK2, 1'b0, ST_OK, 16'd0);
            emit(1'b1, id_at(UNLOCK_A), D_AUTOSEL, 1'b0, ST_OK, 16'd0);
            emit(1'b0, id_at(32'd0), 8'd0, 1'b0, ST_OK, 16'd0);
            phase = PH_POST0;
          end
          PH_POST0: begin
            id_hi = c.data;
            emit(1'b0, id_at(32'd1), 8'd0, 1'b0, ST_OK, 16'd0);
            phase = PH_POST1;
          end
          PH_POST1: begin
            code = {id_hi, c.data};
            emit(1'b1, id_at(UNLOCK_A), D_UNLOCK1, 1'b0, ST_OK, 16'd0);
            emit(1'b1, id_at(UNLOCK_B), D_UNLOCK2, 1'b0, ST_OK, 16'd0);
            emit(1'b1, id_at(UNLOCK_A), D_RESET, 1'b0, ST_OK, 16'd0);
            emit(1'b0, 32'd0, 8'd0, 1'b1, ST_OK, (code == prior_code) ? 16'd0 : code);
            phase = PH_IDLE;
          end
          default: ;
        endcase
      end
      if (burst.size() > 0) begin
        r = burst.pop_back();
        r.last_of_run = 1'b1;
        burst.push_back(r);
        foreach (burst[i]) bus_ops_due.push_back(burst[i]);
        burst.delete();
      end
    endfunction

    function string show(res_t r);
      return $sformatf("wr=%0d adr=%h dat=%h done=%0d st=%0d fam=%h last=%0d",
                       r.bus_write, r.bus_address, r.bus_data, r.command_done,
                       r.status, r.family_code, r.last_of_run);
    endfunction

    function void check_result(res_t act);
      res_t want;
      if (bus_ops_due.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected bus result: %s", show(act));
        return;
      end
      want = bus_ops_due.pop_front();
      if (want.bus_write !== act.bus_write || want.bus_address !== act.bus_address ||
          want.bus_data !== act.bus_data || want.command_done !== act.command_done ||
          want.status !== act.status || want.family_code !== act.family_code ||
          want.last_of_run !== act.last_of_run) begin
        failures++;
        if (failures <= 10)
          $display("bus result mismatch: expected %s, got %s", show(want), show(act));
      end
    endfunction
  endclass

  // no-progress limit, far above the longest quiet stretch of a good run
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  fpes_cmd_if cmd_ch ();
  fpes_res_if res_ch ();

  flash_bus_scoreboard sb;

  bit          no_idle;       // both sides skip idling while set
  bit          steady_phase;  // skips idling on both sides for a whole phase
  int          sent_items;
  logic [22:0] cur_limit;     // poll limit currently programmed
  int          quiet_cycles;

  flash_program_erase_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transaction monitor on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_ch.valid && cmd_ch.ready) sb.note_input(cmd_ch.payload);
      if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.payload);
    end
  end

  // watchdog: too long without any transaction ends the run
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("flash_program_erase_sequencer regression: fail");
        $finish;
      end
    end
  end

  // result sink: random stall before each transaction
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      stall = (no_idle || steady_phase) ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  // one command or read response, after a random gap; returns at the edge
  // where it was accepted, with valid still high
  task automatic send_item(input logic [1:0] op, input logic [31:0] adr,
                           input logic [7:0] dat);
    int   gap;
    cmd_t item;
    gap = (no_idle || steady_phase) ? 0 : $urandom_range(0, 13);
    item.opcode  = op;
    item.address = adr;
    item.data    = dat;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.payload <= item;
    cmd_ch.valid   <= 1'b1;
    do @(posedge clk); while (!cmd_ch.ready);
    sent_items++;
  endtask

  // hold off the sender until every predicted result has come out
  task automatic quiesce();
    cmd_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
      while (sb.pending() != 0) @(posedge clk);
      // ignored transactions may still be in flight
      repeat (10) @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  // feed read responses until the sequencer is back in idle
  task automatic settle_sequence();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.busy()) begin
      send_item(OP_READ_RSP, $urandom, sb.closing_byte());
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // all three registers, one per cycle; only called while quiet
  task automatic apply_settings(input logic [1:0] sh, input logic [31:0] base,
                                input logic [22:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ADDR_SHIFT;
    cfg_data  <= {30'd0, sh};
    sb.write_reg(CFG_ADDR_SHIFT, {30'd0, sh});
    @(posedge clk);
    cfg_index <= CFG_DEVICE_START;
    cfg_data  <= base;
    sb.write_reg(CFG_DEVICE_START, base);
    @(posedge clk);
    cfg_index <= CFG_POLL_LIMIT;
    cfg_data  <= {9'd0, lim};
    sb.write_reg(CFG_POLL_LIMIT, {9'd0, lim});
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_limit = lim;
  endtask

  // program or erase, then polls ending in ok, device error or timeout
  task automatic poll_command(input logic [1:0] op);
    logic [31:0] adr;
    logic [7:0]  dat;
    logic [7:0]  want;
    logic [7:0]  b;
    logic [22:0] eff;
    int          ending;
    int          n;
    int          cap;
    adr    = $urandom;
    dat    = 8'($urandom);
    want   = (op == OP_PROGRAM) ? dat : ERASED_BYTE;
    eff    = (cur_limit == 23'd0) ? 23'd1 : cur_limit;
    ending = $urandom_range(0, 2);
    // timeouts only where the limit is small enough to reach
    if (ending == 2 && eff > 23'd6) ending = $urandom_range(0, 1);
    cap = (eff > 23'd5) ? 4 : int'(eff) - 1;
    n   = (ending == 2) ? int'(eff) : $urandom_range(0, cap);
    send_item(op, adr, dat);
    repeat (n) begin
      // busy status: no match, error bit clear
      b = 8'($urandom);
      b[ERR_BIT] = 1'b0;
      if (b == want) b[0] = ~b[0];
      send_item(OP_READ_RSP, $urandom, b);
    end
    if (ending == 0) begin
      send_item(OP_READ_RSP, $urandom, want);
    end else if (ending == 1) begin
      b = 8'($urandom);
      b[ERR_BIT] = 1'b1;
      if (b == want) b[0] = ~b[0];
      send_item(OP_READ_RSP, $urandom, b);
    end
  endtask

  // identify with code before and after autoselect, equal now and then
  task automatic identify_run();
    logic [15:0] before_code;
    logic [15:0] after_code;
    before_code = 16'($urandom);
    after_code  = ($urandom_range(0, 9) < 3) ? before_code : 16'($urandom);
    send_item(OP_IDENTIFY, $urandom, 8'($urandom));
    send_item(OP_READ_RSP, $urandom, before_code[15:8]);
    send_item(OP_READ_RSP, $urandom, before_code[7:0]);
    send_item(OP_READ_RSP, $urandom, after_code[15:8]);
    send_item(OP_READ_RSP, $urandom, after_code[7:0]);
  endtask

  // mostly well-formed command sequences, some single noise transactions
  task automatic random_group();
    int pick;
    pick    = $urandom_range(0, 99);
    no_idle = ($urandom_range(0, 7) == 0);
    if (pick < 40) poll_command(OP_PROGRAM);
    else if (pick < 60) poll_command(OP_ERASE);
    else if (pick < 82) identify_run();
    else send_item(2'($urandom_range(0, 3)), $urandom, 8'($urandom));
    // sender waits for the result side to catch up now and then
    if ($urandom_range(0, 19) == 0) quiesce();
  endtask

  initial begin
    int start_count;
    sb            = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.payload = '0;
    no_idle       = 1'b0;
    steady_phase  = 1'b0;
    sent_items    = 0;
    quiet_cycles  = 0;
    cur_limit     = POLL_LIMIT_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset settings
    // program at the bottom of the address space, immediate match
    send_item(OP_PROGRAM, 32'h0000_0000, 8'h00);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'h00);
    // program at the top, one busy poll first
    send_item(OP_PROGRAM, 32'hffff_ffff, 8'hff);
    send_item(OP_READ_RSP, 32'hffff_ffff, 8'h00);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'hff);
    // match with the error bit set still counts as ok
    send_item(OP_PROGRAM, 32'h1234_5678, 8'h2c);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'h2c);
    // erase ending in a device error
    send_item(OP_ERASE, 32'h00ab_cdef, 8'h00);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'h7f);
    // identify where nothing changes: family code zero
    send_item(OP_IDENTIFY, 32'h0000_0000, 8'h00);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'h01);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'h20);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'h01);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'h20);
    // read response while idle is dropped
    send_item(OP_READ_RSP, 32'hffff_ffff, 8'hff);
    // command while busy is dropped
    send_item(OP_ERASE, 32'h8765_4321, 8'hff);
    send_item(OP_PROGRAM, 32'h0f0f_0f0f, 8'h5a);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'hff);

    // extremes: shift three, top base address, poll limit zero
    quiesce();
    apply_settings(2'd3, 32'hffff_ffff, 23'd0);
    // limit of zero times out on the first busy poll
    send_item(OP_PROGRAM, 32'h5a5a_a5a5, 8'h55);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'h00);
    // identify with a changed code
    send_item(OP_IDENTIFY, 32'hffff_ffff, 8'hff);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'h01);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'ha4);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'hc2);
    send_item(OP_READ_RSP, 32'h0000_0000, 8'h00);

    // random part, one register setting per phase
    for (int p = 0; p < 6; p++) begin
      settle_sequence();
      quiesce();
      case (p)
        0:       apply_settings(2'd1, $urandom, 23'd3);
        1:       apply_settings(2'd2, 32'h0000_0000, 23'd1);
        2:       apply_settings(2'd0, 32'hffff_ffff, 23'h7f_ffff);
        3:       apply_settings(2'($urandom_range(0, 3)), $urandom,
                                23'($urandom_range(2, 6)));
        4:       apply_settings(2'd2, $urandom, POLL_LIMIT_RESET);
        default: apply_settings(2'd3, $urandom, 23'd4);
      endcase
      // one phase runs back to back with no idling at all
      steady_phase = (p == 1);
      start_count  = sent_items;
      while (sent_items - start_count < 42) random_group();
    end
    steady_phase = 1'b0;
    no_idle      = 1'b0;

    // drain and give late results a chance to show up
    settle_sequence();
    quiesce();
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("flash_program_erase_sequencer regression: pass");
    end else begin
      $display("flash_program_erase_sequencer regression: fail");
    end
    $finish;
  end

endmodule
